/* rtl/lerf_pkg.sv */
`timescale 1ns / 1ps

package lerf_pkg;

  localparam int ELEM_W     = 32;
  localparam int RUN_W      = 8;
  localparam int COUNT_W    = 8;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 8;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COL_COUNT = 8'd1;

  localparam logic [RUN_W-1:0] RUN_ONE = 8'd1;
  localparam logic [RUN_W-1:0] RUN_MAX = 8'd255;

  typedef logic [ELEM_W-1:0]  elem_t;
  typedef logic [RUN_W-1:0]   run_t;
  typedef logic [COUNT_W-1:0] count_t;

  // One line buffer entry: the element of the row above and the runs ending there
  typedef struct packed {
    elem_t value;
    run_t  vert;
    run_t  diag;
    run_t  anti;
  } line_entry_t;

  localparam int LINE_W = $bits(line_entry_t);

  // Saturating run extension
  function automatic run_t run_next(input logic same, input run_t run);
    if (!same) begin
      return RUN_ONE;
    end else if (run == RUN_MAX) begin
      return RUN_MAX;
    end else begin
      return run + RUN_ONE;
    end
  endfunction

endpackage

/* rtl/lerf_channels.sv */
`timescale 1ns / 1ps

// Matrix element channel
interface lerf_elem_if;
  import lerf_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [ELEM_W-1:0] element_value;
  modport source (output valid, output element_value, input ready);
  modport sink (input valid, input element_value, output ready);
endinterface

// Result channel
interface lerf_result_if;
  import lerf_pkg::*;
  logic             valid;
  logic             ready;
  logic [RUN_W-1:0] longest_run;
  modport source (output valid, output longest_run, input ready);
  modport sink (input valid, input longest_run, output ready);
endinterface

// Configuration write channel
interface lerf_cfg_if;
  import lerf_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

/* rtl/longest_equal_run_four_directions.sv */
`timescale 1ns / 1ps

// Channel     Dir  Payload                      Request meaning
// elements    in   element_value (32b signed)   one matrix element, raster order
// result      out  longest_run (8b)             longest run, once per frame
// cfg         in   index (8b), data (8b)        0: row_count, 1: col_count
//
// One element per cycle when not stalled; a result appears the cycle after the last
// element of a frame. The row above lives in two copies of a line RAM, read at
// the column and the column to its right; reads are issued in the cycle before use.
// Reset (rst, synchronous) and every cfg write drive elements.ready low in the cycle after.
// A waiting result only stalls the last element of the next frame.
module longest_equal_run_four_directions
  import lerf_pkg::*;
#(
  parameter int MAX_COLS = 128,
  parameter int MAX_ROWS = 128
) (
  input  logic          clk,
  input  logic          rst,
  lerf_elem_if.sink     elements,
  lerf_result_if.source result,
  lerf_cfg_if.sink      cfg
);

  localparam int CW  = $clog2(MAX_COLS);
  localparam int RW  = $clog2(MAX_ROWS);
  localparam int CCW = $clog2(MAX_COLS + 1);
  localparam int RCW = $clog2(MAX_ROWS + 1);

  // Registers
  count_t      row_count;
  count_t      col_count;
  logic [CW-1:0] col_position;
  logic [RW-1:0] row_position;
  run_t        horizontal_run;
  run_t        best_run;
  elem_t       left_value;
  elem_t       upleft_value;
  run_t        upleft_run;
  logic        stale;
  logic        fwd_a;
  logic        fwd_b;
  line_entry_t fwd_data;
  logic        out_valid;
  run_t        out_run;

  // Combinational signals
  logic [CCW-1:0] cols;
  logic [RCW-1:0] rows;
  logic [CW-1:0]  cur_col;
  logic [CCW-1:0] col_inc;
  logic [RCW-1:0] row_inc;
  logic           end_row;
  logic           end_frame;
  logic           above;
  logic           left_ok;
  logic           right_ok;
  logic           accept;
  logic           in_ready;
  elem_t          v;
  line_entry_t    ram_a_rd;
  line_entry_t    ram_b_rd;
  line_entry_t    entry_c;
  line_entry_t    entry_r;
  line_entry_t    wr_entry;
  run_t           h;
  run_t           vr;
  run_t           dr;
  run_t           ar;
  run_t           m;
  logic [CW-1:0]  col_position_next;
  logic [RW-1:0]  row_position_next;
  logic [CW-1:0]  rd_a;
  logic [CW-1:0]  rd_b;
  logic [CCW-1:0] rd_a_inc;

  // Clamp a column position to the current column count
  function automatic logic [CW-1:0] clamp_col(input logic [CW-1:0] pos,
                                              input logic [CCW-1:0] n);
    if (CCW'(pos) >= n) begin
      return CW'(n - CCW'(1));
    end else begin
      return pos;
    end
  endfunction

  // Effective counts: zero acts as one, large values saturate at the bound
  always_comb begin
    if (col_count == '0) begin
      cols = CCW'(1);
    end else if (32'(col_count) > 32'(MAX_COLS)) begin
      cols = CCW'(MAX_COLS);
    end else begin
      cols = CCW'(col_count);
    end
    if (row_count == '0) begin
      rows = RCW'(1);
    end else if (32'(row_count) > 32'(MAX_ROWS)) begin
      rows = RCW'(MAX_ROWS);
    end else begin
      rows = RCW'(row_count);
    end
  end

  // Position bookkeeping
  assign cur_col   = clamp_col(col_position, cols);
  assign above     = (row_position != '0);
  assign left_ok   = (cur_col != '0);
  assign col_inc   = CCW'(cur_col) + CCW'(1);
  assign right_ok  = (col_inc < cols);
  assign end_row   = (col_inc >= cols);
  assign row_inc   = end_row ? RCW'(row_position) + RCW'(1) : RCW'(row_position);
  assign end_frame = (row_inc >= rows);

  // Handshake: only the last element of a frame needs a free result slot
  assign in_ready       = !stale && (!end_frame || !out_valid || result.ready);
  assign elements.ready = in_ready;
  assign accept         = elements.valid && in_ready;
  assign v              = elem_t'(elements.element_value);

  // Line data with bypass of last cycle's write
  assign entry_c = fwd_a ? fwd_data : ram_a_rd;
  assign entry_r = fwd_b ? fwd_data : ram_b_rd;

  // Run extension in four directions
  always_comb begin
    h = run_next(left_ok && (v == left_value), horizontal_run);
    vr = run_next(above && (v == entry_c.value), entry_c.vert);
    dr = run_next(above && left_ok && (v == upleft_value), upleft_run);
    if (above && right_ok) begin
      ar = run_next(v == entry_r.value, entry_r.anti);
    end else begin
      ar = RUN_ONE;
    end
    m = best_run;
    if (h > m) m = h;
    if (vr > m) m = vr;
    if (dr > m) m = dr;
    if (ar > m) m = ar;
    wr_entry = '{value: v, vert: vr, diag: dr, anti: ar};
  end

  // Position after this cycle and read addresses for the next one
  always_comb begin
    col_position_next = col_position;
    row_position_next = row_position;
    if (accept) begin
      if (end_row || end_frame) begin
        col_position_next = '0;
      end else begin
        col_position_next = CW'(col_inc);
      end
      if (end_frame) begin
        row_position_next = '0;
      end else begin
        row_position_next = RW'(row_inc);
      end
    end
    rd_a     = clamp_col(col_position_next, cols);
    rd_a_inc = CCW'(rd_a) + CCW'(1);
    if (rd_a_inc >= CCW'(MAX_COLS)) begin
      rd_b = '0;
    end else begin
      rd_b = CW'(rd_a_inc);
    end
  end

  // Line RAM copy read at the current column
  lerf_ram #(
    .WIDTH (LINE_W),
    .DEPTH (MAX_COLS)
  ) u_line_a (
    .clk   (clk),
    .we    (accept),
    .waddr (cur_col),
    .wdata (wr_entry),
    .raddr (rd_a),
    .rdata (ram_a_rd)
  );

  // Line RAM copy read at the column to the right
  lerf_ram #(
    .WIDTH (LINE_W),
    .DEPTH (MAX_COLS)
  ) u_line_b (
    .clk   (clk),
    .we    (accept),
    .waddr (cur_col),
    .wdata (wr_entry),
    .raddr (rd_b),
    .rdata (ram_b_rd)
  );

  // Write bypass: a read issued at the written address returns old data
  always_ff @(posedge clk) begin
    fwd_data <= wr_entry;
    if (rst) begin
      fwd_a <= 1'b0;
      fwd_b <= 1'b0;
    end else begin
      fwd_a <= accept && (rd_a == cur_col);
      fwd_b <= accept && (rd_b == cur_col);
    end
  end

  // Configuration registers; reads reissue in the cycle after a write
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count <= count_t'(1);
      col_count <= count_t'(1);
      stale     <= 1'b1;
    end else begin
      stale <= cfg.valid;
      if (cfg.valid) begin
        unique case (cfg.index)
          REG_ROW_COUNT: row_count <= count_t'(cfg.data);
          REG_COL_COUNT: col_count <= count_t'(cfg.data);
          default: ;
        endcase
      end
    end
  end

  // Frame state
  always_ff @(posedge clk) begin
    if (rst) begin
      col_position   <= '0;
      row_position   <= '0;
      horizontal_run <= RUN_ONE;
      best_run       <= RUN_ONE;
      left_value     <= '0;
      upleft_value   <= '0;
      upleft_run     <= '0;
    end else if (accept) begin
      col_position <= col_position_next;
      row_position <= row_position_next;
      if (end_frame) begin
        horizontal_run <= RUN_ONE;
        best_run       <= RUN_ONE;
        left_value     <= '0;
        upleft_value   <= '0;
        upleft_run     <= '0;
      end else begin
        best_run   <= m;
        left_value <= v;
        if (end_row) begin
          horizontal_run <= RUN_ONE;
          upleft_value   <= '0;
          upleft_run     <= '0;
        end else begin
          horizontal_run <= h;
          upleft_value   <= entry_c.value;
          upleft_run     <= entry_c.diag;
        end
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept && end_frame) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
    if (accept && end_frame) begin
      out_run <= m;
    end
  end

  assign result.valid       = out_valid;
  assign result.longest_run = out_run;

endmodule

/* rtl/lerf_ram.sv */
`timescale 1ns / 1ps

// Simple dual-port RAM, registered read, read returns old data on a collision
module lerf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
